>>> sv/idfp_pkg.sv
// ----------------------------------------------------------------------------
// idfp_pkg
// Types, character codes and result builders for the line parser.
// ----------------------------------------------------------------------------
package idfp_pkg;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;

    localparam logic [7:0] FIELD_COUNT_RESET   = 8'd3;
    localparam logic [7:0] MAX_ID_LENGTH_RESET = 8'd16;

    typedef enum logic {
        REG_FIELD_COUNT   = 1'b0,
        REG_MAX_ID_LENGTH = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_CHAR   = 2'd0,
        KIND_FIELD  = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_VALID       = 3'd0,
        ST_EMPTY_LINE  = 3'd1,
        ST_ID_SPACE    = 3'd2,
        ST_EMPTY_FIELD = 3'd3,
        ST_TOO_MANY    = 3'd4,
        ST_NON_DIGIT   = 3'd5,
        ST_WRONG_COUNT = 3'd6
    } status_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  position;
        logic [7:0]  char_out;
        logic [31:0] field_value;
        status_t     status;
        logic        last;
    } out_item_t;

    // Results of one item: up to two, the first is shown first.
    typedef struct packed {
        out_item_t  r0;
        out_item_t  r1;
        logic [1:0] count;
    } res_pair_t;

    typedef struct packed {
        logic       in_fields;
        logic [7:0] id_length;
        logic [7:0] field_index;
        logic       digit_seen;
        logic       skip_next;
    } parse_state_t;

    function automatic out_item_t make_char(input logic [7:0] pos, input logic [7:0] ch);
        out_item_t r;
        r = '0;
        r.kind = KIND_CHAR;
        r.position = pos;
        r.char_out = ch;
        return r;
    endfunction

    function automatic out_item_t make_field(input logic [7:0] pos,
                                             input logic [31:0] val);
        out_item_t r;
        r = '0;
        r.kind = KIND_FIELD;
        r.position = pos;
        r.field_value = val;
        return r;
    endfunction

    function automatic out_item_t make_status(input status_t st);
        out_item_t r;
        r = '0;
        r.kind = KIND_STATUS;
        r.status = st;
        return r;
    endfunction

endpackage

>>> sv/idfp_step.sv
// ----------------------------------------------------------------------------
// idfp_step
// Combinational parse step: one character against the parser state, giving
// the next state and up to two results.
// ----------------------------------------------------------------------------
module idfp_step #(
    parameter int VALUE_WIDTH = 32
) (
    input  idfp_pkg::in_item_t     item,
    input  idfp_pkg::parse_state_t st,
    input  logic [VALUE_WIDTH-1:0] acc,
    input  logic [7:0]             field_count,
    input  logic [7:0]             max_id_length,
    output idfp_pkg::parse_state_t st_next,
    output logic [VALUE_WIDTH-1:0] acc_next,
    output idfp_pkg::res_pair_t    res
);
    import idfp_pkg::*;

    logic [7:0]             b;
    logic                   eos;
    logic                   line_end;
    logic                   is_space;
    logic                   is_digit;
    logic [3:0]             digit;
    logic [VALUE_WIDTH+3:0] acc_ext;
    logic [VALUE_WIDTH+3:0] acc_mac;
    logic [31:0]            acc32;
    logic [8:0]             fi_plus1;
    logic [8:0]             fc_ext;
    logic                   clear;
    status_t                end_status;

    assign b        = item.in_byte;
    assign eos      = item.end_of_stream;
    assign line_end = eos || b == CH_LF || b == CH_CR;
    assign is_space = b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF;
    assign is_digit = b >= CH_ZERO && b <= CH_NINE;
    assign digit    = 4'(b - CH_ZERO);
    assign acc32    = 32'(acc);
    assign fi_plus1 = {1'b0, st.field_index} + 9'd1;
    assign fc_ext   = {1'b0, field_count};

    // Times ten plus digit; any bit above the value width means saturation.
    assign acc_ext = {4'd0, acc};
    assign acc_mac = (acc_ext << 3) + (acc_ext << 1) + {{VALUE_WIDTH{1'b0}}, digit};

    always_comb begin
        priority if (st.in_fields && !st.digit_seen) begin
            end_status = ST_EMPTY_FIELD;
        end else if ((st.id_length == 8'd0 && st.field_index != 8'd0) ||
                     (st.id_length != 8'd0 && fi_plus1 != fc_ext)) begin
            end_status = ST_WRONG_COUNT;
        end else if (st.id_length == 8'd0) begin
            end_status = ST_EMPTY_LINE;
        end else begin
            end_status = ST_VALID;
        end
    end

    always_comb begin
        st_next  = st;
        acc_next = acc;
        res      = '0;
        clear    = 1'b0;
        st_next.skip_next = 1'b0;
        priority if (st.skip_next && !eos) begin
            // The byte after a CR line end is swallowed, unless it is an end-of-stream mark.
        end else if (line_end) begin
            clear = 1'b1;
            st_next.skip_next = !eos && b == CH_CR;
            if (st.in_fields && st.digit_seen) begin
                res.r0    = make_field(st.field_index, acc32);
                res.r1    = make_status(end_status);
                res.count = 2'd2;
            end else begin
                res.r0    = make_status(end_status);
                res.count = 2'd1;
            end
        end else if (!st.in_fields) begin
            priority if (b == CH_COMMA) begin
                st_next.in_fields = 1'b1;
            end else if (is_space) begin
                clear     = 1'b1;
                res.r0    = make_status(ST_ID_SPACE);
                res.count = 2'd1;
            end else if (st.id_length < max_id_length) begin
                res.r0            = make_char(st.id_length, b);
                res.count         = 2'd1;
                st_next.id_length = st.id_length + 8'd1;
            end else begin
                // Characters past the configured id length are dropped.
            end
        end else if (b == CH_COMMA) begin
            if (!st.digit_seen) begin
                clear     = 1'b1;
                res.r0    = make_status(ST_EMPTY_FIELD);
                res.count = 2'd1;
            end else if (fi_plus1 >= fc_ext) begin
                clear     = 1'b1;
                res.r0    = make_field(st.field_index, acc32);
                res.r1    = make_status(ST_TOO_MANY);
                res.count = 2'd2;
            end else begin
                res.r0              = make_field(st.field_index, acc32);
                res.count           = 2'd1;
                st_next.field_index = fi_plus1[7:0];
                st_next.digit_seen  = 1'b0;
                acc_next            = '0;
            end
        end else if (is_digit) begin
            acc_next = (acc_mac[VALUE_WIDTH+3:VALUE_WIDTH] != 4'd0) ? '1 :
                       acc_mac[VALUE_WIDTH-1:0];
            st_next.digit_seen = 1'b1;
        end else begin
            clear     = 1'b1;
            res.r0    = make_status(ST_NON_DIGIT);
            res.count = 2'd1;
        end

        if (clear) begin
            st_next.in_fields   = 1'b0;
            st_next.id_length   = 8'd0;
            st_next.field_index = 8'd0;
            st_next.digit_seen  = 1'b0;
            acc_next            = '0;
        end

        if (res.count == 2'd2) begin
            res.r1.last = 1'b1;
        end else if (res.count == 2'd1) begin
            res.r0.last = 1'b1;
        end
    end

endmodule

>>> sv/idfp_outbuf.sv
// ----------------------------------------------------------------------------
// idfp_outbuf
// Two-entry result register that presents the results of one item in order.
// ----------------------------------------------------------------------------
module idfp_outbuf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  idfp_pkg::res_pair_t  res,
    output logic                 free,
    output logic                 m_valid,
    input  logic                 m_ready,
    output idfp_pkg::out_item_t  m_item
);
    import idfp_pkg::*;

    out_item_t  slot0_reg;
    out_item_t  slot1_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    // Free when nothing will be left after this cycle's hand-over.
    assign free    = cnt_reg == 2'd0 || (cnt_reg == 2'd1 && m_ready);
    assign m_valid = cnt_reg != 2'd0;
    assign m_item  = slot0_reg;

    always_comb begin
        cnt_next = cnt_reg;
        if (load) begin
            cnt_next = res.count;
        end else if (m_valid && m_ready) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot0_reg <= res.r0;
            slot1_reg <= res.r1;
        end else if (m_valid && m_ready) begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule

>>> sv/id_and_decimal_field_line_parser.sv
// ----------------------------------------------------------------------------
// id_and_decimal_field_line_parser
// Parses id,value,value,... lines one character per item and reports id
// characters, decimal field values and a status for every entry.
// ----------------------------------------------------------------------------
//  Channel  | Ports                       | Moves
//  ---------+-----------------------------+----------------------------------
//  input    | s_valid, s_ready, s_item    | one character or end of stream
//  result   | m_valid, m_ready, m_item    | id char, field value or status
//  config   | cfg_we, cfg_index, cfg_wdata| field count, max id length
//
// An item is registered on entry and parsed once the two-entry result
// register can take its results: one item per cycle while the result
// side keeps up; an item with two results holds it until the second is
// taken. Reset clears the parser state and the result register and loads
// the register defaults. A stall on the result side backs up into s_ready.
// ----------------------------------------------------------------------------
module id_and_decimal_field_line_parser #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  idfp_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output idfp_pkg::out_item_t m_item,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_wdata
);
    import idfp_pkg::*;

    in_item_t               in_item_reg;
    logic                   in_vld_reg;
    parse_state_t           st_reg;
    parse_state_t           st_next;
    logic [VALUE_WIDTH-1:0] acc_reg;
    logic [VALUE_WIDTH-1:0] acc_next;
    logic [7:0]             field_count_reg;
    logic [7:0]             max_id_length_reg;
    res_pair_t              res;
    logic                   out_free;
    logic                   adv;

    assign adv     = in_vld_reg && out_free;
    assign s_ready = !in_vld_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_vld_reg <= 1'b1;
        end else if (adv) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= '0;
            acc_reg <= '0;
        end else if (adv) begin
            st_reg  <= st_next;
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_count_reg   <= FIELD_COUNT_RESET;
            max_id_length_reg <= MAX_ID_LENGTH_RESET;
        end else if (cfg_we) begin
            unique case (reg_index_t'(cfg_index))
                REG_FIELD_COUNT:   field_count_reg   <= cfg_wdata;
                REG_MAX_ID_LENGTH: max_id_length_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    idfp_step #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_step (
        .item         (in_item_reg),
        .st           (st_reg),
        .acc          (acc_reg),
        .field_count  (field_count_reg),
        .max_id_length(max_id_length_reg),
        .st_next      (st_next),
        .acc_next     (acc_next),
        .res          (res)
    );

    idfp_outbuf u_outbuf (
        .aclk   (aclk),
        .aresetn(aresetn),
        .load   (adv),
        .res    (res),
        .free   (out_free),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

endmodule

>>> tb/id_and_decimal_field_line_parser_tb.sv
// ----------------------------------------------------------------------------
// id_and_decimal_field_line_parser_tb
// Streams text lines into the parser, one character or end-of-stream mark
// per item, and checks every id character, field value and entry status that
// comes back against a parse of the same stream kept in the bench. A short
// hand-written sequence comes first, then random well-formed, broken and noisy
// lines under several register settings, with bursty input and a stalling
// receiver.
// ----------------------------------------------------------------------------
module id_and_decimal_field_line_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import idfp_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_HOLD     = 300;
    localparam int REPORT_LIMIT  = 10;
    localparam longint unsigned VALUE_MAX = 64'h0000_0000_FFFF_FFFF;

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_item_t   s_item    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_item_t  m_item;
    logic       cfg_we    = 1'b0;
    logic       cfg_index = 1'b0;
    logic [7:0] cfg_wdata = 8'h00;

    // Characters waiting to be sent and results the parse says must come.
    in_item_t  text_stream[$];
    out_item_t due_parse_results[$];
    int        chars_queued = 0;

    // Register copies and parse state of the bench.
    int              field_count_setting   = FIELD_COUNT_RESET;
    int              max_id_length_setting = MAX_ID_LENGTH_RESET;
    logic            in_fields    = 1'b0;
    int              id_chars     = 0;
    int              field_number = 0;
    longint unsigned field_acc    = 0;
    logic            have_digit   = 1'b0;
    logic            skip_pending = 1'b0;

    int burst_left = 0;
    int gap_left   = 0;
    int rx_mode      = 0;
    int rx_mode_left = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int cycle_count    = 0;
    int mismatch_count = 0;

    id_and_decimal_field_line_parser u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic out_item_t result_of(input kind_t k, input logic [7:0] pos,
                                            input logic [7:0] ch, input logic [31:0] val,
                                            input status_t st);
        out_item_t r;
        r = '0;
        r.kind = k;
        r.position = pos;
        r.char_out = ch;
        r.field_value = val;
        r.status = st;
        return r;
    endfunction

    function automatic out_item_t close_entry(input status_t st);
        in_fields = 1'b0;
        id_chars = 0;
        field_number = 0;
        field_acc = 0;
        have_digit = 1'b0;
        return result_of(KIND_STATUS, 8'd0, 8'h00, 32'h0, st);
    endfunction

    function automatic void parse_char(input in_item_t it);
        out_item_t       step_out[$];
        logic [7:0]      b;
        logic            eos;
        status_t         st;
        longint unsigned dgt;
        b = it.in_byte;
        eos = it.end_of_stream;
        if (skip_pending) begin
            skip_pending = 1'b0;
            if (!eos)
                return;
        end
        if (eos || b == CH_LF || b == CH_CR) begin
            if (in_fields && have_digit)
                step_out.push_back(result_of(KIND_FIELD, 8'(field_number), 8'h00,
                                             field_acc[31:0], ST_VALID));
            if (in_fields && !have_digit)
                st = ST_EMPTY_FIELD;
            else if ((id_chars == 0 && field_number > 0) ||
                     (id_chars > 0 && field_number + 1 != field_count_setting))
                st = ST_WRONG_COUNT;
            else if (id_chars == 0)
                st = ST_EMPTY_LINE;
            else
                st = ST_VALID;
            step_out.push_back(close_entry(st));
            if (!eos && b == CH_CR)
                skip_pending = 1'b1;
        end else if (!in_fields) begin
            if (b == CH_COMMA) begin
                in_fields = 1'b1;
            end else if (b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF) begin
                step_out.push_back(close_entry(ST_ID_SPACE));
            end else if (id_chars < max_id_length_setting) begin
                step_out.push_back(result_of(KIND_CHAR, 8'(id_chars), b, 32'h0, ST_VALID));
                id_chars++;
            end
        end else if (b == CH_COMMA) begin
            if (!have_digit) begin
                step_out.push_back(close_entry(ST_EMPTY_FIELD));
            end else begin
                step_out.push_back(result_of(KIND_FIELD, 8'(field_number), 8'h00,
                                             field_acc[31:0], ST_VALID));
                if (field_number + 1 >= field_count_setting) begin
                    step_out.push_back(close_entry(ST_TOO_MANY));
                end else begin
                    field_number++;
                    field_acc = 0;
                    have_digit = 1'b0;
                end
            end
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
            dgt = b - CH_ZERO;
            // Values stick at the top of the range once they would overflow.
            if (field_acc > (VALUE_MAX - dgt) / 10)
                field_acc = VALUE_MAX;
            else
                field_acc = field_acc * 10 + dgt;
            have_digit = 1'b1;
        end else begin
            step_out.push_back(close_entry(ST_NON_DIGIT));
        end
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i])
            due_parse_results.push_back(step_out[i]);
    endfunction

    // Sender: bursts of random length with random gaps in between.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_item <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready)
                parse_char(s_item);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (text_stream.size() > 0) begin
                    s_valid <= 1'b1;
                    s_item <= text_stream.pop_front();
                    if (burst_left <= 1) begin
                        if ($urandom_range(0, 3) == 0) begin
                            burst_left <= $urandom_range(40, 160);
                            gap_left <= 0;
                        end else begin
                            burst_left <= $urandom_range(1, 12);
                            gap_left <= $urandom_range(0, 8);
                        end
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: changes its stall pattern now and then, and holds off for a
    // long stretch whenever one is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_mode_left <= 0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_served + 1;
            hold_left <= LONG_HOLD;
            m_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode <= $urandom_range(0, 3);
                rx_mode_left <= $urandom_range(16, 96);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    m_ready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_ready <= (cycle_count % 5) != 0;
                end
            endcase
        end
    end

    task automatic report_mismatch(input string what, input out_item_t want,
                                   input out_item_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%s: expected kind %0d pos %0d char %02h value %0d status %0d last %0b, got kind %0d pos %0d char %02h value %0d status %0d last %0b",
                     what, want.kind, want.position, want.char_out, want.field_value,
                     want.status, want.last, got.kind, got.position, got.char_out,
                     got.field_value, got.status, got.last);
    endtask

    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_parse_results.size() == 0) begin
                report_mismatch("unexpected result", '0, m_item);
            end else begin
                want = due_parse_results.pop_front();
                if (m_item.kind !== want.kind || m_item.position !== want.position ||
                    m_item.char_out !== want.char_out ||
                    m_item.field_value !== want.field_value ||
                    m_item.status !== want.status || m_item.last !== want.last)
                    report_mismatch("wrong result", want, m_item);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("id_and_decimal_field_line_parser: mismatch");
            $finish;
        end
    end

    task automatic push_char(input logic [7:0] b);
        in_item_t it;
        it.in_byte = b;
        it.end_of_stream = 1'b0;
        text_stream.push_back(it);
        chars_queued++;
    endtask

    task automatic push_eos();
        in_item_t it;
        it.in_byte = 8'($urandom_range(0, 255));
        it.end_of_stream = 1'b1;
        text_stream.push_back(it);
        chars_queued++;
    endtask

    task automatic push_text(input string s);
        foreach (s[i])
            push_char(s[i]);
    endtask

    // Any byte that is neither a separator, a line end nor whitespace.
    function automatic logic [7:0] id_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_COMMA || b == CH_LF || b == CH_CR || b == CH_SPACE ||
               b == CH_TAB || b == CH_VT || b == CH_FF);
        return b;
    endfunction

    task automatic push_id_chars(input int n);
        repeat (n) push_char(id_char());
    endtask

    function automatic int pick_id_length();
        int cap;
        cap = (max_id_length_setting + 2 < 12) ? max_id_length_setting + 2 : 12;
        if ($urandom_range(0, 15) == 0)
            return 0;
        return $urandom_range(1, cap);
    endfunction

    task automatic push_digits(input int n);
        logic nines;
        nines = ($urandom_range(0, 3) == 0);
        repeat (n) push_char(nines ? CH_NINE : CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // Mostly short numbers; now and then ones long enough to saturate.
    task automatic push_fields(input int nf);
        for (int i = 0; i < nf; i++) begin
            if (i > 0)
                push_char(CH_COMMA);
            if ($urandom_range(0, 3) == 0)
                push_digits($urandom_range(9, 12));
            else
                push_digits($urandom_range(1, 4));
        end
    endtask

    // A CR ending is mostly followed by something for the parser to skip, else by an end of stream.
    task automatic push_line_end();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            push_char(CH_LF);
        end else if (r < 7) begin
            push_char(CH_CR);
            push_char(8'($urandom_range(0, 255)));
        end else if (r == 7) begin
            push_char(CH_CR);
            push_char(CH_LF);
        end else if (r == 8) begin
            push_char(CH_CR);
            push_eos();
        end else begin
            push_eos();
        end
    endtask

    task automatic push_good_line();
        push_id_chars(pick_id_length());
        push_char(CH_COMMA);
        push_fields((field_count_setting == 0) ? 1 : field_count_setting);
        push_line_end();
    endtask

    task automatic push_broken_line();
        logic [7:0] b;
        int         nf;
        case ($urandom_range(0, 6))
            0: begin
                push_id_chars($urandom_range(0, 3));
                case ($urandom_range(0, 3))
                    0: push_char(CH_SPACE);
                    1: push_char(CH_TAB);
                    2: push_char(CH_VT);
                    default: push_char(CH_FF);
                endcase
                push_char(CH_COMMA);
                push_fields(1);
                push_line_end();
            end
            1: begin
                push_id_chars(pick_id_length());
                push_char(CH_COMMA);
                nf = $urandom_range(0, 2);
                push_fields(nf);
                if (nf > 0)
                    push_char(CH_COMMA);
                push_char(CH_COMMA);
                push_fields(1);
                push_line_end();
            end
            2: begin
                push_id_chars(pick_id_length());
                push_char(CH_COMMA);
                push_fields((field_count_setting <= 8) ? field_count_setting + 1 : 2);
                push_line_end();
            end
            3: begin
                push_id_chars(pick_id_length());
                if (field_count_setting > 1) begin
                    push_char(CH_COMMA);
                    nf = (field_count_setting - 1 < 8) ? field_count_setting - 1 : 8;
                    push_fields($urandom_range(1, nf));
                end
                push_line_end();
            end
            4: begin
                push_id_chars(pick_id_length());
                push_char(CH_COMMA);
                push_digits($urandom_range(0, 3));
                do
                    b = 8'($urandom_range(0, 255));
                while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_COMMA ||
                       b == CH_LF || b == CH_CR);
                push_char(b);
                push_id_chars(2);
                push_line_end();
            end
            5: begin
                push_id_chars(pick_id_length());
                push_char(CH_COMMA);
                nf = (field_count_setting == 0) ? 1 : field_count_setting;
                push_fields((nf < 6) ? nf : 6);
                push_char(CH_COMMA);
                push_line_end();
            end
            default: begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 6) == 0)
                        push_eos();
                    else
                        push_char(8'($urandom_range(0, 255)));
                end
            end
        endcase
    endtask

    task automatic push_random_lines(input int amount);
        int start;
        int r;
        start = chars_queued;
        while (chars_queued - start < amount) begin
            r = $urandom_range(0, 9);
            if (r < 7)
                push_good_line();
            else
                push_broken_line();
        end
    endtask

    task automatic wait_until_drained();
        do
            @(negedge aclk);
        while (text_stream.size() != 0 || s_valid || due_parse_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_FIELD_COUNT)
            field_count_setting = val;
        else
            max_id_length_setting = val;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Hand-written entries under the reset settings: empty lines, id
        // whitespace, empty field, too many fields, non-digit, wrong count,
        // the skip after CR and an end of stream that cancels a pending skip.
        push_char(CH_LF);
        push_eos();
        push_char(CH_TAB);
        push_text(",,");
        push_text("k,1,2,3,");
        push_text("m,x");
        push_text("n,5");
        push_char(CH_CR);
        push_char(8'hFF);
        push_char(CH_CR);
        push_eos();
        push_char(8'h00);
        push_eos();
        wait_until_drained();

        // The receiver holds off while plenty of items are queued.
        push_random_lines(80);
        hold_requests = hold_requests + 1;
        wait_until_drained();
        push_random_lines(40);
        wait_until_drained();

        write_reg(REG_FIELD_COUNT, 8'd1);
        write_reg(REG_MAX_ID_LENGTH, 8'd0);
        push_random_lines(60);
        wait_until_drained();

        // Widest settings: a line with every field used.
        write_reg(REG_FIELD_COUNT, 8'd255);
        write_reg(REG_MAX_ID_LENGTH, 8'd255);
        push_text("ab,");
        for (int i = 0; i < 255; i++) begin
            if (i > 0)
                push_char(CH_COMMA);
            push_char(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        push_char(CH_LF);
        push_text("c,1,2");
        push_line_end();
        wait_until_drained();

        // With no fields allowed every entry with fields must fail.
        write_reg(REG_FIELD_COUNT, 8'd0);
        write_reg(REG_MAX_ID_LENGTH, 8'd8);
        push_random_lines(40);
        wait_until_drained();

        write_reg(REG_FIELD_COUNT, 8'd4);
        write_reg(REG_MAX_ID_LENGTH, 8'd3);
        push_random_lines(70);
        wait_until_drained();

        write_reg(REG_FIELD_COUNT, 8'd2);
        write_reg(REG_MAX_ID_LENGTH, 8'd1);
        push_random_lines(60);
        wait_until_drained();

        if (mismatch_count == 0 && due_parse_results.size() == 0)
            $display("id_and_decimal_field_line_parser: match");
        else
            $display("id_and_decimal_field_line_parser: mismatch");
        $finish;
    end

endmodule
